[rtl/median_of_two_sorted_arrays_defines.svh]
// Assertion helpers for the median_of_two_sorted_arrays RTL
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_DEFINES_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_DEFINES_SVH

// clocked assertion with explicit clock and active-low reset
`define MTSA_ASSERT_CLK(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define MTSA_ASSERT(lbl, prop, msg) \
	`MTSA_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[rtl/mtsa_pkg.sv]
`timescale 1ns / 1ps
package mtsa_pkg;

	localparam int DATA_W = 32;
	localparam int RES_W  = 33;
	localparam int EXT_W  = 34;

	localparam logic signed [EXT_W-1:0] NEG_INF = -(EXT_W'(64'sd1) <<< 32);
	localparam logic signed [EXT_W-1:0] POS_INF = EXT_W'(64'sd1) <<< 32;

	typedef struct packed {
		logic                     func;
		logic signed [DATA_W-1:0] elem_value;
		logic                     last;
	} elem_t;

	typedef struct packed {
		logic signed [RES_W-1:0] median_x2;
		logic                    overflow;
	} res_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CALC = 6'b000010,
		ST_RDL  = 6'b000100,
		ST_RDR  = 6'b001000,
		ST_EVAL = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

[rtl/mtsa_ram.sv]
`timescale 1ns / 1ps
module mtsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/median_of_two_sorted_arrays.sv]
`timescale 1ns / 1ps
// Median of two ascending lists of signed 32-bit values.
// elem channel: one element per beat; func picks the list (0 first, 1 second),
// last ends the data set. Elements for a full list (DEPTH entries) are
// dropped and reported through res.overflow.
// res channel: one beat per data set, res.median_x2 = twice the median
// (one implied fractional bit), taken after the search over the shorter list.
// Loading accepts one element per cycle while idle, stored through the RAM write port.
// After the last beat the block stalls elem while it searches: each search
// step computes the cuts, reads each RAM's single read port twice (left, then
// right neighbors) and compares, at most clog2(m+1)+1 steps for a shorter list
// of m entries, followed by a final cut check when the search runs out without
// a valid cut; then the result register is loaded. The result register holds
// a beat while res_stall is high; loading the next data set continues
// meanwhile, and a finished search waits until the result register is free.
// Reset clears counts, drop flag and the result valid flag; list contents are
// only read below the current counts and need no clearing.
module median_of_two_sorted_arrays
	import mtsa_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  elem_valid,
	output logic  elem_stall,
	input  elem_t elem,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

`include "median_of_two_sorted_arrays_defines.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	state_t state_q;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic          cap_q;

	logic               swap_q, odd_q, ovf_q;
	logic [CW-1:0]      m_q, n_q, half_q;
	logic signed [CW:0] lo_q, hi_q;
	logic [CW-1:0]      c1_q, c2_q;
	logic signed [EXT_W-1:0] l1_q, l2_q;
	logic signed [RES_W-1:0] med_q;

	res_t res_q;
	logic res_valid_q;

	logic acc, full_a, full_b, we_a, we_b, drop, res_load;
	logic [CW-1:0] na, nb, m_new, n_new;
	logic [CW:0]   tot;
	logic [AW-1:0] sh_addr, lg_addr, raddr_a, raddr_b;
	logic [DATA_W-1:0] rdata_a, rdata_b, rd_sh, rd_lg;
	logic signed [CW+1:0] lh;
	logic signed [EXT_W-1:0] r1, r2, left, right;
	logic signed [EXT_W:0]   msum;
	logic part_ok;

	assign acc    = elem_valid && !elem_stall;
	assign full_a = (cnt_a_q >= DEPTH_C);
	assign full_b = (cnt_b_q >= DEPTH_C);
	assign we_a   = acc && !elem.func && !full_a;
	assign we_b   = acc && elem.func && !full_b;
	assign drop   = acc && ((!elem.func && full_a) || (elem.func && full_b));
	assign na     = cnt_a_q + CW'(we_a);
	assign nb     = cnt_b_q + CW'(we_b);
	assign m_new  = (na > nb) ? nb : na;
	assign n_new  = (na > nb) ? na : nb;
	assign tot    = {1'b0, na} + {1'b0, nb} + (CW+1)'(1);

	assign elem_stall = (state_q != ST_IDLE);
	assign res_load   = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	// left neighbors on the first read, right neighbors on the second
	assign sh_addr = (state_q == ST_RDL) ? AW'(c1_q - CW'(1)) : AW'(c1_q);
	assign lg_addr = (state_q == ST_RDL) ? AW'(c2_q - CW'(1)) : AW'(c2_q);
	assign raddr_a = swap_q ? lg_addr : sh_addr;
	assign raddr_b = swap_q ? sh_addr : lg_addr;
	assign rd_sh   = swap_q ? rdata_b : rdata_a;
	assign rd_lg   = swap_q ? rdata_a : rdata_b;

	mtsa_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (elem.elem_value),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mtsa_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (elem.elem_value),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign lh = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};

	assign r1 = (c1_q >= m_q) ? POS_INF : EXT_W'($signed(rd_sh));
	assign r2 = (c2_q >= n_q) ? POS_INF : EXT_W'($signed(rd_lg));
	assign part_ok = (l1_q <= r2) && (l2_q <= r1);
	assign left    = (l1_q > l2_q) ? l1_q : l2_q;
	assign right   = (r1 < r2) ? r1 : r2;
	assign msum    = odd_q ? ({left[EXT_W-1], left} <<< 1)
	                       : ({left[EXT_W-1], left} + {right[EXT_W-1], right});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			cap_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (elem.last) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							cap_q   <= 1'b0;
							state_q <= ST_CALC;
						end else begin
							cnt_a_q <= na;
							cnt_b_q <= nb;
							cap_q   <= cap_q | drop;
						end
					end
				end
				ST_CALC: begin
					state_q <= (lo_q <= hi_q) ? ST_RDL : ST_DONE;
				end
				ST_RDL: begin
					state_q <= ST_RDR;
				end
				ST_RDR: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= part_ok ? ST_DONE : ST_CALC;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc && elem.last) begin
					swap_q <= (na > nb);
					m_q    <= m_new;
					n_q    <= n_new;
					half_q <= tot[CW:1];
					odd_q  <= na[0] ^ nb[0];
					ovf_q  <= cap_q | drop;
					lo_q   <= '0;
					hi_q   <= $signed({1'b0, m_new});
				end
			end
			ST_CALC: begin
				if (lo_q <= hi_q) begin
					c1_q <= lh[CW:1];
					c2_q <= half_q - lh[CW:1];
				end else begin
					med_q <= '0;
				end
			end
			ST_RDR: begin
				l1_q <= (c1_q == '0) ? NEG_INF : EXT_W'($signed(rd_sh));
				l2_q <= (c2_q == '0) ? NEG_INF : EXT_W'($signed(rd_lg));
			end
			ST_EVAL: begin
				if (part_ok) begin
					med_q <= msum[RES_W-1:0];
				end else if (l1_q > r2) begin
					hi_q <= $signed({1'b0, c1_q}) - (CW+1)'(1);
				end else begin
					lo_q <= $signed({1'b0, c1_q}) + (CW+1)'(1);
				end
			end
			ST_DONE: begin
				if (res_load) begin
					res_q.median_x2 <= med_q;
					res_q.overflow  <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`MTSA_ASSERT(a_cnt_range, (cnt_a_q <= DEPTH_C) && (cnt_b_q <= DEPTH_C), "count beyond depth")
	`MTSA_ASSERT(a_c1_range, (state_q == ST_EVAL) |-> (c1_q <= m_q), "cut beyond short list")
	`MTSA_ASSERT(a_c2_range, (state_q == ST_EVAL) |-> (c2_q <= n_q), "cut beyond long list")
	`MTSA_ASSERT(a_done_load, (state_q == ST_DONE) && !res_valid_q |=> res_valid_q && (state_q == ST_IDLE), "result not loaded")

endmodule

[test/median_of_two_sorted_arrays_test.sv]
`timescale 1ns / 1ps
module median_of_two_sorted_arrays_test;
	import mtsa_pkg::*;

	localparam int DEPTH = 1024;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic TO_FIRST = 1'b0;
	localparam logic TO_SECOND = 1'b1;
	localparam int INT_MIN = 32'sh8000_0000;
	localparam int INT_MAX = 32'sh7fff_ffff;
	localparam longint BELOW_ALL = -(64'sd1 <<< 32);
	localparam longint ABOVE_ALL = 64'sd1 <<< 32;

	typedef struct {
		elem_t beat;
		bit    wait_idle;
	} beat_plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic elem_valid = 1'b0;
	logic elem_stall;
	elem_t elem = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int list_store [2][DEPTH];
	int unsigned list_len [2];
	bit dropped;
	res_t medians_due [$];
	beat_plan_t to_send [$];
	int unsigned errors, results_seen, idle_cycles;
	int unsigned send_gap, send_calm, stall_left, recv_calm;
	bit held;
	int unsigned items_made, sets_made;

	median_of_two_sorted_arrays #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.elem(elem),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #5 clk = ~clk;

	// search cuts over the shorter list; the first list wins a tie
	function automatic longint twice_median();
		logic s, o;
		longint m, n, lo, hi, half, c1, c2, l1, l2, r1, r2;
		s = (list_len[TO_FIRST] > list_len[TO_SECOND]) ? TO_SECOND : TO_FIRST;
		o = ~s;
		m = list_len[s];
		n = list_len[o];
		lo = 0;
		hi = m;
		half = (m + n + 1) / 2;
		while (lo <= hi) begin
			c1 = lo + (hi - lo) / 2;
			c2 = half - c1;
			l1 = (c1 == 0) ? BELOW_ALL : longint'(list_store[s][c1 - 1]);
			l2 = (c2 <= 0) ? BELOW_ALL : longint'(list_store[o][c2 - 1]);
			r1 = (c1 >= m) ? ABOVE_ALL : longint'(list_store[s][c1]);
			r2 = (c2 >= n) ? ABOVE_ALL : longint'(list_store[o][c2]);
			if (l1 <= r2 && l2 <= r1) begin
				if (l2 > l1) begin
					l1 = l2;
				end
				if (r2 < r1) begin
					r1 = r2;
				end
				return ((m + n) % 2 == 0) ? l1 + r1 : 2 * l1;
			end
			if (l1 > r2) begin
				hi = c1 - 1;
			end else begin
				lo = c1 + 1;
			end
		end
		return 0;
	endfunction

	function automatic void absorb_beat(elem_t b);
		res_t r;
		if (list_len[b.func] < DEPTH) begin
			list_store[b.func][list_len[b.func]] = b.elem_value;
			list_len[b.func]++;
		end else begin
			dropped = 1'b1;
		end
		if (b.last) begin
			r.median_x2 = RES_W'(twice_median());
			r.overflow = dropped;
			medians_due.push_back(r);
			list_len[TO_FIRST] = 0;
			list_len[TO_SECOND] = 0;
			dropped = 1'b0;
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 2) begin
			calm = $urandom_range(40, 150);
			return 0;
		end
		if (r < 110) begin
			return 0;
		end
		if (r < 170) begin
			return $urandom_range(1, 3);
		end
		if (r < 195) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic push_beat(logic f, int v, logic l, bit wait_idle);
		beat_plan_t p;
		p.beat.func = f;
		p.beat.elem_value = v;
		p.beat.last = l;
		p.wait_idle = wait_idle;
		to_send.push_back(p);
		items_made++;
	endtask

	task automatic queue_random_set(int unsigned na, int unsigned nb, bit wait_idle,
		bit force_end, logic end_on);
		int vals [2][2*DEPTH];
		int unsigned want_len [2];
		int unsigned pos [2];
		int unsigned left, k, j;
		int s, mode, tmp;
		longint acc, step_max;
		logic side;
		want_len[TO_FIRST] = na;
		want_len[TO_SECOND] = nb;
		for (s = 0; s < 2; s++) begin
			mode = (want_len[s] > 40) ? 1 : $urandom_range(0, 2);
			step_max = (mode == 1) ? 3 : 64'h2000_0000;
			acc = (mode == 2) ? longint'(INT_MIN) + $urandom_range(0, 15)
				: longint'(int'($urandom));
			for (k = 0; k < want_len[s]; k++) begin
				if (mode == 0) begin
					vals[s][k] = $urandom;
					for (j = k; j > 0 && vals[s][j-1] > vals[s][j]; j--) begin
						tmp = vals[s][j];
						vals[s][j] = vals[s][j-1];
						vals[s][j-1] = tmp;
					end
				end else begin
					if (k != 0) begin
						acc += $urandom_range(0, int'(step_max));
					end
					if (acc > INT_MAX) begin
						acc = INT_MAX;
					end
					vals[s][k] = int'(acc);
				end
			end
			// occasionally break the ordering
			if (want_len[s] >= 2 && $urandom_range(0, 39) == 0) begin
				k = $urandom_range(0, want_len[s] - 1);
				j = $urandom_range(0, want_len[s] - 1);
				tmp = vals[s][k];
				vals[s][k] = vals[s][j];
				vals[s][j] = tmp;
			end
		end
		pos[TO_FIRST] = 0;
		pos[TO_SECOND] = 0;
		left = na + nb;
		while (left != 0) begin
			if (pos[TO_FIRST] == na) begin
				side = TO_SECOND;
			end else if (pos[TO_SECOND] == nb) begin
				side = TO_FIRST;
			end else if (force_end && want_len[end_on] - pos[end_on] == 1) begin
				side = ~end_on;
			end else begin
				side = ($urandom_range(1, left) <= nb - pos[TO_SECOND]) ? TO_SECOND : TO_FIRST;
			end
			push_beat(side, vals[side][pos[side]], left == 1, wait_idle && left == na + nb);
			pos[side]++;
			left--;
		end
		sets_made++;
	endtask

	always @(posedge clk) begin : driver
		beat_plan_t nxt;
		logic fire, load;
		if (!arst_n) begin
			elem_valid <= 1'b0;
		end else begin
			fire = elem_valid && !elem_stall;
			load = 1'b0;
			if (fire) begin
				absorb_beat(elem);
			end
			if (!elem_valid || fire) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (to_send.size() != 0) begin
					load = !(to_send[0].wait_idle && medians_due.size() != 0);
				end
				if (load) begin
					nxt = to_send.pop_front();
					elem <= nxt.beat;
					send_gap = next_gap(send_calm);
				end
				elem_valid <= load;
			end
		end
	end

	always @(posedge clk) begin : monitor
		res_t want;
		logic stall;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (medians_due.size() == 0) begin
					report("result beat with none due", longint'(res.median_x2), 0);
				end else begin
					want = medians_due.pop_front();
					if (res.median_x2 !== want.median_x2) begin
						report("median_x2", longint'(res.median_x2), longint'(want.median_x2));
					end
					if (res.overflow !== want.overflow) begin
						report("overflow", longint'(res.overflow), longint'(want.overflow));
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!held && results_seen == 25) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
				stall_left = next_gap(recv_calm);
			end
			stall = stall_left != 0;
			if (stall) begin
				stall_left--;
			end
			res_stall <= stall;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (elem_valid && !elem_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned na, nb;
		// both extremes, doubled and summed
		push_beat(TO_FIRST, INT_MAX, 1'b0, 1'b0);
		push_beat(TO_SECOND, INT_MAX, 1'b1, 1'b0);
		push_beat(TO_FIRST, INT_MIN, 1'b0, 1'b0);
		push_beat(TO_SECOND, INT_MIN, 1'b1, 1'b0);
		// second list empty, odd total
		push_beat(TO_FIRST, -5, 1'b0, 1'b0);
		push_beat(TO_FIRST, 0, 1'b0, 1'b0);
		push_beat(TO_FIRST, 7, 1'b1, 1'b0);
		// first list empty
		push_beat(TO_SECOND, 1, 1'b0, 1'b0);
		push_beat(TO_SECOND, 2, 1'b1, 1'b0);
		// first list longer
		push_beat(TO_FIRST, 1, 1'b0, 1'b0);
		push_beat(TO_SECOND, 2, 1'b0, 1'b0);
		push_beat(TO_FIRST, 3, 1'b1, 1'b0);
		// equal lengths
		push_beat(TO_SECOND, 4, 1'b0, 1'b0);
		push_beat(TO_FIRST, -1, 1'b0, 1'b0);
		push_beat(TO_SECOND, 6, 1'b0, 1'b0);
		push_beat(TO_FIRST, 10, 1'b1, 1'b0);
		// unsorted
		push_beat(TO_FIRST, 5, 1'b0, 1'b0);
		push_beat(TO_SECOND, 2, 1'b0, 1'b0);
		push_beat(TO_FIRST, 1, 1'b0, 1'b0);
		push_beat(TO_SECOND, 0, 1'b0, 1'b0);
		push_beat(TO_FIRST, 3, 1'b1, 1'b0);
		push_beat(TO_FIRST, INT_MIN, 1'b0, 1'b0);
		push_beat(TO_SECOND, INT_MAX, 1'b1, 1'b0);

		while (items_made < 1250 || sets_made < 21) begin
			if (sets_made == 20) begin
				// one list overruns; the set ends on a dropped beat
				if ($urandom_range(0, 1)) begin
					queue_random_set(DEPTH + 3, 3, 1'b1, 1'b1, TO_FIRST);
				end else begin
					queue_random_set(3, DEPTH + 3, 1'b1, 1'b1, TO_SECOND);
				end
			end else begin
				na = $urandom_range(0, 6);
				nb = $urandom_range(0, 6);
				if ($urandom_range(0, 19) == 0) begin
					na = $urandom_range(10, 40);
				end
				if ($urandom_range(0, 19) == 0) begin
					nb = $urandom_range(10, 40);
				end
				if (na + nb == 0) begin
					na = 1;
				end
				queue_random_set(na, nb, sets_made == 0 || sets_made % 20 == 10, 1'b0,
					TO_FIRST);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (to_send.size() != 0 || elem_valid || medians_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
